[src/sbo_pkg.sv]
// ----------------------------------------------------------------------------
// Stochastic breakpoint oscillator package
// Sequencer states, register indexes, reset values and the LFSR step.
// ----------------------------------------------------------------------------
package sbo_pkg;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_AMP_M,
		ST_AMP_WALK,
		ST_FRAC_SET,
		ST_FRAC_DIV,
		ST_MAP0,
		ST_MAP1,
		ST_MAP2,
		ST_POS,
		ST_DUR_M,
		ST_DUR_WALK,
		ST_SEARCH,
		ST_READ_R,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_QUOT_SET,
		ST_QUOT_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		REG_POT_A_LOW   = 3'd0,
		REG_POT_A_HIGH  = 3'd1,
		REG_POT_B_LOW   = 3'd2,
		REG_POT_B_HIGH  = 3'd3,
		REG_OUTPUT_GAIN = 3'd4,
		REG_MAX_AMP     = 3'd5,
		REG_RANDOM_SEED = 3'd6
	} cfg_reg_t;

	localparam logic [15:0] POT_A_LOW_RST  = 16'd9830;
	localparam logic [15:0] POT_A_HIGH_RST = 16'd19661;
	localparam logic [15:0] POT_B_LOW_RST  = 16'd655;
	localparam logic [15:0] POT_B_HIGH_RST = 16'd28836;
	localparam logic [14:0] GAIN_RST       = 15'd6554;
	localparam logic [14:0] MAX_AMP_RST    = 15'd3277;
	localparam logic [31:0] SEED_RST       = 32'd1;

	localparam logic [31:0] LFSR_MASK      = 32'hA300_0000;
	localparam logic [16:0] FRAC_ONE       = 17'h1_0000;
	localparam logic [15:0] AMP_FLOOR_BASE = 16'hF333;   // -3277
	localparam logic [11:0] STEP_RST       = 12'd1311;
	localparam logic [7:0]  DUR_RST        = 8'd20;
	localparam logic [7:0]  MIN_DUR_RST    = 8'd20;
	localparam logic [7:0]  MAX_DUR_RST    = 8'd100;
	localparam logic [7:0]  MIN_DUR_BASE   = 8'd10;
	localparam logic [21:0] SPAN_BASE      = 22'd655360;
	localparam logic [32:0] RECIP_20       = 33'd52429;  // 2^20 / 20, rounded up
	localparam logic [4:0]  FRAC_STEPS     = 5'd16;
	localparam logic [4:0]  QUOT_STEPS     = 5'd24;

	// Eight shifts of the Galois LFSR; a draw takes two of these.
	function automatic logic [31:0] lfsr_step8(input logic [31:0] s);
		logic [31:0] v;
		v = s;
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
		end
		return v;
	endfunction

endpackage

[src/stochastic_breakpoint_oscillator.sv]
// ----------------------------------------------------------------------------
// Stochastic breakpoint oscillator
// Dynamic stochastic synthesis voice: one Q1.15 sample per audio tick.
// ----------------------------------------------------------------------------
// One transaction on the input channel is one audio tick and yields exactly
// one output transaction. The block works on one tick at a time and holds
// in_stall high from acceptance until the result is loaded into the output
// register; a result waiting there does not block the next tick. A tick runs
// through acceptance, the amplitude walk (only with block_start), two pot
// mappings (each a division unless the reading is outside the calibrated span
// or the span is flat), the duration walk (only at a period end), the segment
// search, and the interpolation and rounding division; the finished sample may
// then wait for the output register to free up. The tick time is set by the
// per-breakpoint walks over the single-port breakpoint stores and by the shared
// bit-serial divider. After reset a clearing pass loads the breakpoint stores
// before the first tick is taken.
// Configuration writes are always accepted but must only be issued while the
// block is idle.
module stochastic_breakpoint_oscillator #(
	parameter int BREAKPOINTS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// tick input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        pot_a,
	input  logic [15:0]        pot_b,
	input  logic               block_start,
	// sample output
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample,
	output logic               period_restart
);
	import sbo_pkg::*;

	localparam int IW = (BREAKPOINTS > 1) ? $clog2(BREAKPOINTS) : 1;
	localparam int PW = $clog2(BREAKPOINTS * 159 + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(BREAKPOINTS - 1);

	state_t state_q, state_d;

	// configuration
	logic [15:0] pa_lo_q, pa_hi_q, pb_lo_q, pb_hi_q;
	logic [14:0] gain_q, maxa_q;
	logic [31:0] lfsr_q, lfsr_nx;

	// control state
	logic [IW-1:0] idx_q;
	logic [1:0]    ph_q;
	logic          sel_b_q;
	logic [PW-1:0] pos_q, plen_q;
	logic [11:0]   step_q;
	logic signed [15:0] mina_q;
	logic [7:0]    mind_q, maxd_q;
	logic          out_valid_q;
	logic [4:0]    div_cnt_q;

	// payload
	logic [15:0]   pa_q, pb_q;
	logic [16:0]   a_q, b_q;
	logic [18:0]   m_q;
	logic [35:0]   prod_q;
	logic [PW-1:0] start_q;
	logic          restart_q;
	logic [7:0]    dur_l_q, off_q;
	logic signed [15:0] fl_q, fr_q;
	logic signed [25:0] mac_q;
	logic signed [40:0] x_q;
	logic          neg_q;
	logic [15:0]   div_r_q, div_v_q;
	logic [23:0]   div_n_q;
	logic signed [15:0] sample_q;
	logic          period_restart_q;

	// breakpoint stores, single address, registered read
	logic [7:0]         dur_mem    [BREAKPOINTS];
	logic signed [15:0] live_mem   [BREAKPOINTS];
	logic signed [15:0] frozen_mem [BREAKPOINTS];
	logic [7:0]         dur_rd_q;
	logic signed [15:0] live_rd_q, frozen_rd_q;
	logic               dur_we, live_we, frozen_we;
	logic [7:0]         dur_wd;
	logic signed [15:0] live_wd, frozen_wd;

	logic cfg_wr, in_acc, slot_free, lfsr_adv;
	logic [15:0] u;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign u         = lfsr_q[31:16];
	assign lfsr_nx   = lfsr_step8(lfsr_q);

	// ---------------------------------------------------------------------
	// Pot to fraction: trap the flat and out-of-range cases, else divide
	// ---------------------------------------------------------------------
	logic [15:0] pot_s, lo_s, hi_s;
	logic signed [16:0] num_raw, den_raw, num_adj, den_adj;
	logic        frac_special;
	logic [16:0] frac_val;

	assign pot_s   = sel_b_q ? pb_q : pa_q;
	assign lo_s    = sel_b_q ? pb_lo_q : pa_lo_q;
	assign hi_s    = sel_b_q ? pb_hi_q : pa_hi_q;
	assign num_raw = $signed({1'b0, pot_s}) - $signed({1'b0, lo_s});
	assign den_raw = $signed({1'b0, hi_s}) - $signed({1'b0, lo_s});
	assign num_adj = den_raw[16] ? -num_raw : num_raw;
	assign den_adj = den_raw[16] ? -den_raw : den_raw;

	always_comb begin
		frac_special = 1'b1;
		frac_val     = '0;
		if (den_raw == '0) begin
			frac_val = (pot_s >= lo_s) ? FRAC_ONE : '0;
		end else if (num_adj <= 17'sd0) begin
			frac_val = '0;
		end else if (num_adj >= den_adj) begin
			frac_val = FRAC_ONE;
		end else begin
			frac_special = 1'b0;
		end
	end

	// Shared restoring divider: one quotient bit per cycle
	logic [16:0] div_t;
	logic        div_ge;
	logic [15:0] div_r_nx;
	logic [23:0] div_n_nx;

	assign div_t    = {div_r_q, div_n_q[23]};
	assign div_ge   = div_t >= {1'b0, div_v_q};
	assign div_r_nx = div_ge ? 16'(div_t - {1'b0, div_v_q}) : div_t[15:0];
	assign div_n_nx = {div_n_q[22:0], div_ge};

	// Pot mapping
	logic [32:0] a_rec, b_rec;
	logic [12:0] b_tenth;
	logic [21:0] span;
	logic [37:0] sp_prod;
	logic [23:0] b_prod;
	logic [7:0]  mind_c, maxd_c;

	assign a_rec   = a_q * RECIP_20;
	assign b_rec   = b_q * RECIP_20;
	assign b_tenth = b_rec[31:19];
	assign span    = SPAN_BASE + 22'(a_q) * 22'd40;
	assign sp_prod = span * u;
	assign b_prod  = b_q * 24'd100;
	assign mind_c  = MIN_DUR_BASE + {2'b00, sp_prod[37:32]};
	assign maxd_c  = mind_c + b_prod[23:16];

	// Walk step scale and signed step
	logic signed [16:0] amp_diff;
	logic [28:0] amp_m_full;
	logic [19:0] dur_m_full;
	logic [35:0] step_prod;

	assign amp_diff   = $signed({2'b00, maxa_q}) - $signed({mina_q[15], mina_q});
	assign amp_m_full = amp_diff[16:0] * step_q;
	assign dur_m_full = (maxd_q - mind_q) * step_q;
	assign step_prod  = {m_q, 1'b0} * u;

	// Amplitude update
	logic signed [20:0] amp_stp;
	logic signed [21:0] amp_sum, amp_lo, amp_hi;
	logic signed [15:0] amp_new;

	assign amp_stp = $signed({1'b0, prod_q[35:16]}) - $signed({2'b00, m_q});
	assign amp_sum = $signed({{6{live_rd_q[15]}}, live_rd_q}) + $signed({amp_stp[20], amp_stp});
	assign amp_lo  = $signed({{6{mina_q[15]}}, mina_q});
	assign amp_hi  = $signed({7'd0, maxa_q});

	always_comb begin
		if (amp_sum < amp_lo) begin
			amp_new = mina_q;
		end else if (amp_sum > amp_hi) begin
			amp_new = $signed({1'b0, maxa_q});
		end else begin
			amp_new = amp_sum[15:0];
		end
	end

	// Duration update: step truncated toward zero to whole samples
	logic signed [36:0] dur_s;
	logic [36:0]        dur_abs;
	logic [4:0]         dur_mag;
	logic signed [9:0]  dur_d, dur_sum;
	logic [7:0]         dur_new;

	assign dur_s   = $signed({17'd0, prod_q[35:16]}) - $signed({18'd0, m_q});
	assign dur_abs = dur_s[36] ? 37'(-dur_s) : 37'(dur_s);
	assign dur_mag = dur_abs[20:16];
	assign dur_d   = dur_s[36] ? -$signed({5'd0, dur_mag}) : $signed({5'd0, dur_mag});
	assign dur_sum = $signed({2'b00, dur_rd_q}) + dur_d;

	always_comb begin
		if (dur_sum < $signed({2'b00, mind_q})) begin
			dur_new = mind_q;
		end else if (dur_sum > $signed({2'b00, maxd_q})) begin
			dur_new = maxd_q;
		end else begin
			dur_new = dur_sum[7:0];
		end
	end

	// Position and segment search
	logic [PW-1:0] pos_nx;
	logic          restart;
	logic [PW:0]   srch_end;
	logic          hit;
	logic [IW-1:0] right_idx;

	assign pos_nx    = pos_q + 1'b1;
	assign restart   = pos_nx >= plen_q;
	assign srch_end  = {1'b0, start_q} + (PW + 1)'(dur_rd_q);
	assign hit       = (idx_q == LAST_IDX) || ({1'b0, pos_q} <= srch_end);
	assign right_idx = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// Interpolation
	logic signed [8:0]  wgt_l, wgt_r;
	logic signed [25:0] mul_a, mul_b;
	logic signed [40:0] x_full;
	logic [40:0]        x_abs, rnd_n;
	logic [23:0]        quot_neg;
	logic signed [15:0] sat_val;

	assign wgt_l    = $signed({1'b0, 8'(dur_l_q - off_q)});
	assign wgt_r    = $signed({1'b0, off_q});
	assign mul_a    = fl_q * wgt_l;
	assign mul_b    = fr_q * wgt_r;
	assign x_full   = mac_q * $signed({1'b0, gain_q});
	assign x_abs    = x_q[40] ? 41'(-x_q) : 41'(x_q);
	assign rnd_n    = x_abs + {19'd0, dur_l_q, 14'd0};
	assign quot_neg = -div_n_q;

	always_comb begin
		if (!neg_q) begin
			sat_val = (div_n_q > 24'd32767) ? 16'sh7FFF : $signed(div_n_q[15:0]);
		end else begin
			sat_val = (div_n_q > 24'd32768) ? 16'sh8000 : $signed(quot_neg[15:0]);
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		dur_we    = 1'b0;
		live_we   = 1'b0;
		frozen_we = 1'b0;
		dur_wd    = dur_new;
		live_wd   = amp_new;
		frozen_wd = live_rd_q;
		lfsr_adv  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				dur_we    = 1'b1;
				live_we   = 1'b1;
				frozen_we = 1'b1;
				dur_wd    = DUR_RST;
				live_wd   = '0;
				frozen_wd = '0;
				if (idx_q == LAST_IDX) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = block_start ? ST_AMP_M : ST_FRAC_SET;
			end
			ST_AMP_M: state_d = ST_AMP_WALK;
			ST_AMP_WALK: begin
				lfsr_adv = (ph_q == 2'd0) || (ph_q == 2'd1);
				if (ph_q == 2'd3) begin
					// breakpoint 0 is pinned to zero after its draw
					live_we = 1'b1;
					if (idx_q == '0) live_wd = '0;
					if (idx_q == LAST_IDX) state_d = ST_FRAC_SET;
				end
			end
			ST_FRAC_SET: begin
				if (!frac_special) begin
					state_d = ST_FRAC_DIV;
				end else if (sel_b_q) begin
					state_d = ST_MAP0;
				end
			end
			ST_FRAC_DIV: begin
				if (div_cnt_q == 5'd1) state_d = sel_b_q ? ST_MAP0 : ST_FRAC_SET;
			end
			ST_MAP0: begin
				lfsr_adv = 1'b1;
				state_d  = ST_MAP1;
			end
			ST_MAP1: begin
				lfsr_adv = 1'b1;
				state_d  = ST_MAP2;
			end
			ST_MAP2: state_d = ST_POS;
			ST_POS: state_d = restart ? ST_DUR_M : ST_SEARCH;
			ST_DUR_M: state_d = ST_DUR_WALK;
			ST_DUR_WALK: begin
				lfsr_adv = (ph_q == 2'd0) || (ph_q == 2'd1);
				if (ph_q == 2'd3) begin
					dur_we    = 1'b1;
					frozen_we = 1'b1;
					if (idx_q == LAST_IDX) state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (ph_q[0] && hit) state_d = ST_READ_R;
			end
			ST_READ_R: begin
				if (ph_q[0]) state_d = ST_MUL0;
			end
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_QUOT_SET;
			ST_QUOT_SET: state_d = ST_QUOT_DIV;
			ST_QUOT_DIV: begin
				if (div_cnt_q == 5'd1) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers, configuration and random state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_lo_q     <= POT_A_LOW_RST;
			pa_hi_q     <= POT_A_HIGH_RST;
			pb_lo_q     <= POT_B_LOW_RST;
			pb_hi_q     <= POT_B_HIGH_RST;
			gain_q      <= GAIN_RST;
			maxa_q      <= MAX_AMP_RST;
			lfsr_q      <= SEED_RST;
			idx_q       <= '0;
			ph_q        <= '0;
			sel_b_q     <= 1'b0;
			pos_q       <= '1;
			plen_q      <= '0;
			step_q      <= STEP_RST;
			mina_q      <= $signed(AMP_FLOOR_BASE);
			mind_q      <= MIN_DUR_RST;
			maxd_q      <= MAX_DUR_RST;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_POT_A_LOW:   pa_lo_q <= cfg_data[15:0];
					REG_POT_A_HIGH:  pa_hi_q <= cfg_data[15:0];
					REG_POT_B_LOW:   pb_lo_q <= cfg_data[15:0];
					REG_POT_B_HIGH:  pb_hi_q <= cfg_data[15:0];
					REG_OUTPUT_GAIN: gain_q  <= cfg_data[14:0];
					REG_MAX_AMP:     maxa_q  <= cfg_data[14:0];
					REG_RANDOM_SEED: ;
					default: ;
				endcase
			end

			// seed write loads the LFSR at once; a zero seed loads one
			if (cfg_wr && (cfg_reg_t'(cfg_index) == REG_RANDOM_SEED)) begin
				lfsr_q <= (cfg_data == '0) ? SEED_RST : cfg_data;
			end else if (lfsr_adv) begin
				lfsr_q <= lfsr_nx;
			end

			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT: idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				ST_IDLE: begin
					idx_q   <= '0;
					ph_q    <= '0;
					sel_b_q <= 1'b0;
				end
				ST_AMP_WALK, ST_DUR_WALK: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd3) begin
						idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
						if (state_q == ST_DUR_WALK && idx_q == LAST_IDX) begin
							plen_q <= start_q + PW'(dur_new);
						end
					end
				end
				ST_FRAC_SET: begin
					if (frac_special) begin
						sel_b_q <= 1'b1;
					end else begin
						div_cnt_q <= FRAC_STEPS;
					end
				end
				ST_FRAC_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == 5'd1) sel_b_q <= 1'b1;
				end
				ST_MAP0: begin
					step_q <= a_rec[31:20];
					mina_q <= $signed(AMP_FLOOR_BASE - {3'b000, b_tenth});
				end
				ST_MAP2: begin
					mind_q <= mind_c;
					maxd_q <= maxd_c;
				end
				ST_POS: begin
					pos_q <= restart ? '0 : pos_nx;
					idx_q <= '0;
					ph_q  <= '0;
				end
				ST_SEARCH: begin
					ph_q <= {1'b0, ~ph_q[0]};
					if (ph_q[0]) idx_q <= hit ? right_idx : idx_q + 1'b1;
				end
				ST_READ_R: ph_q <= {1'b0, ~ph_q[0]};
				ST_QUOT_SET: div_cnt_q <= QUOT_STEPS;
				ST_QUOT_DIV: div_cnt_q <= div_cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pa_q <= pot_a;
			pb_q <= pot_b;
		end
		case (state_q)
			ST_AMP_M: m_q <= 19'(amp_m_full[28:16]);
			ST_AMP_WALK, ST_DUR_WALK: begin
				if (ph_q == 2'd2) prod_q <= step_prod;
				// the search that follows the walk starts again from breakpoint 0
				if (state_q == ST_DUR_WALK && ph_q == 2'd3) begin
					start_q <= (idx_q == LAST_IDX) ? '0 : start_q + PW'(dur_new);
				end
			end
			ST_FRAC_SET: begin
				if (frac_special) begin
					if (sel_b_q) b_q <= frac_val;
					else a_q <= frac_val;
				end else begin
					div_r_q <= num_adj[15:0];
					div_n_q <= '0;
					div_v_q <= den_adj[15:0];
				end
			end
			ST_FRAC_DIV: begin
				div_r_q <= div_r_nx;
				div_n_q <= div_n_nx;
				if (div_cnt_q == 5'd1) begin
					if (sel_b_q) b_q <= {1'b0, div_n_nx[15:0]};
					else a_q <= {1'b0, div_n_nx[15:0]};
				end
			end
			ST_POS: begin
				restart_q <= restart;
				start_q   <= '0;
			end
			ST_DUR_M: m_q <= dur_m_full[18:0];
			ST_SEARCH: begin
				if (ph_q[0]) begin
					if (hit) begin
						dur_l_q <= dur_rd_q;
						off_q   <= 8'(pos_q - start_q);
						fl_q    <= frozen_rd_q;
					end else begin
						start_q <= start_q + PW'(dur_rd_q);
					end
				end
			end
			ST_READ_R: begin
				if (ph_q[0]) fr_q <= frozen_rd_q;
			end
			ST_MUL0: mac_q <= mul_a;
			ST_MUL1: mac_q <= mac_q + mul_b;
			ST_MUL2: x_q <= x_full;
			ST_QUOT_SET: begin
				// round half away from zero: (|x| + den/2) / den, den = dur * 2^15
				neg_q   <= x_q[40];
				div_r_q <= '0;
				div_n_q <= rnd_n[38:15];
				div_v_q <= {8'd0, dur_l_q};
			end
			ST_QUOT_DIV: begin
				div_r_q <= div_r_nx;
				div_n_q <= div_n_nx;
			end
			ST_FIN: begin
				if (slot_free) begin
					sample_q         <= sat_val;
					period_restart_q <= restart_q;
				end
			end
			default: ;
		endcase
	end

	// Breakpoint stores
	always_ff @(posedge clk) begin
		if (dur_we) dur_mem[idx_q] <= dur_wd;
		if (live_we) live_mem[idx_q] <= live_wd;
		if (frozen_we) frozen_mem[idx_q] <= frozen_wd;
		dur_rd_q    <= dur_mem[idx_q];
		live_rd_q   <= live_mem[idx_q];
		frozen_rd_q <= frozen_mem[idx_q];
	end

	assign out_valid      = out_valid_q;
	assign sample         = sample_q;
	assign period_restart = period_restart_q;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("tick accepted without entering the busy sequence");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && slot_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished sample not loaded into output register");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("output valid raised outside the finish step");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (pos_q < plen_q))
		else $error("position outside the current period");

endmodule
